[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define V3_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define V3_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[sv/v3alu_pkg.sv]
// ----------------------------------------------------------------------------
// v3alu_pkg
// types, codes and helpers of the vector alu
// ----------------------------------------------------------------------------
package v3alu_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int SQRT_STEPS = 32;
   localparam int Q_BITS     = FRAC_BITS + 1;
   localparam int DIV_W      = 33 + FRAC_BITS;
   localparam int LATENCY    = 3 + SQRT_STEPS + Q_BITS;

   localparam logic [3:0] FN_NEG    = 4'd0;
   localparam logic [3:0] FN_ADD    = 4'd1;
   localparam logic [3:0] FN_SUB    = 4'd2;
   localparam logic [3:0] FN_SCALE  = 4'd3;
   localparam logic [3:0] FN_DOT    = 4'd4;
   localparam logic [3:0] FN_CROSS  = 4'd5;
   localparam logic [3:0] FN_LENSQ  = 4'd6;
   localparam logic [3:0] FN_LEN    = 4'd7;
   localparam logic [3:0] FN_NORM   = 4'd8;
   localparam logic [3:0] FN_EQ     = 4'd9;
   localparam logic [3:0] FN_ISZERO = 4'd10;
   localparam logic [3:0] FN_ISUNIT = 4'd11;

   localparam logic [30:0] TOL_RESET = 31'd66;
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scale_factor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_x;
      logic signed [31:0] res_y;
      logic signed [31:0] res_z;
      logic signed [31:0] res_scalar;
      logic               test_true;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [3:0]       func;
      logic [2:0][31:0] a;
      logic [2:0][31:0] b;
      logic [5:0][63:0] prod;
   } mul_type;

   typedef struct packed {
      logic             is_len;
      logic             is_norm;
      rsp_type          res;
      logic [63:0]      sum_sq;
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic [31:0]      root;
   } tok_type;

   typedef struct packed {
      logic [31:0] val;
      logic        ov;
   } sat_type;

   function automatic sat_type sat32(input logic signed [65:0] v);
      sat_type r;
      if (v > SAT_HI) begin
         r.val = 32'h7fff_ffff;
         r.ov  = 1'b1;
      end else if (v < SAT_LO) begin
         r.val = 32'h8000_0000;
         r.ov  = 1'b1;
      end else begin
         r.val = v[31:0];
         r.ov  = 1'b0;
      end
      return r;
   endfunction

endpackage

[sv/vec3_alu_unit.sv]
// ----------------------------------------------------------------------------
// vec3_alu_unit
// three-component Q16.16 vector alu, fully pipelined
// ----------------------------------------------------------------------------
// a command beat is taken on a clock edge with start high and busy low; busy
// is high only during reset and for the cycle after, so one beat can enter
// every cycle.
// each beat returns exactly one result beat on rsp_data, marked by rsp_valid
// for one cycle, after the multiply and combine registers, 32 root stages,
// 17 divide stages and the result register. throughput is one beat per
// cycle; the root and divide chains are unrolled, so no item is held back.
// the receiver cannot stall: results are shown once and must be taken.
// the tolerance register is written through csr_valid/csr_data and is always
// ready; write it only while no command is in flight.
// reset clears the pipeline valids and sets the tolerance to 66.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vec3_alu_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  v3alu_pkg::req_type req_data,
   output logic               rsp_valid,
   output v3alu_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [30:0]        csr_data
);

   logic               busy_ff;
   logic [30:0]        tol_ff;
   logic               accept;
   logic               mul_valid;
   v3alu_pkg::mul_type mul_data;
   logic               comb_valid;
   v3alu_pkg::tok_type comb_data;
   logic               sqrt_valid;
   v3alu_pkg::tok_type sqrt_data;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         tol_ff  <= v3alu_pkg::TOL_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_data;
         end
      end
   end

   v3alu_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (mul_valid),
      .out_data  (mul_data)
   );

   v3alu_comb u_comb (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_data   (mul_data),
      .tolerance (tol_ff),
      .out_valid (comb_valid),
      .out_data  (comb_data)
   );

   v3alu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (comb_valid),
      .in_data   (comb_data),
      .out_valid (sqrt_valid),
      .out_data  (sqrt_data)
   );

   v3alu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_data   (sqrt_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   `V3_ASSERT(a_latency, clock, reset, accept |-> ##(v3alu_pkg::LATENCY) rsp_valid, "result beat missing at fixed latency")
   `V3_ASSERT(a_test_no_ovf, clock, reset, !(rsp_valid && rsp_data.test_true && rsp_data.overflow), "test result with overflow")
   `V3_ASSERT(a_test_scalar, clock, reset, !(rsp_valid && rsp_data.test_true) || (rsp_data.res_scalar == '0), "test result with scalar")
   `V3_ASSERT_NEXT(a_csr_write, clock, reset, csr_valid && csr_ready, tol_ff == $past(csr_data), "tolerance write lost")

endmodule

[sv/v3alu_mul.sv]
// ----------------------------------------------------------------------------
// v3alu_mul
// operand select and six parallel 32x32 multipliers, registered
// ----------------------------------------------------------------------------
module v3alu_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  v3alu_pkg::req_type  in_data,
   output logic                out_valid,
   output v3alu_pkg::mul_type  out_data
);

   logic signed [31:0] x [6];
   logic signed [31:0] y [6];
   v3alu_pkg::mul_type data_in;
   v3alu_pkg::mul_type data_ff;
   logic               valid_ff;

   always_comb begin
      x[0] = in_data.a_x;  y[0] = in_data.b_x;
      x[1] = in_data.a_y;  y[1] = in_data.b_y;
      x[2] = in_data.a_z;  y[2] = in_data.b_z;
      x[3] = in_data.a_x;  y[3] = in_data.a_x;
      x[4] = in_data.a_y;  y[4] = in_data.a_y;
      x[5] = in_data.a_z;  y[5] = in_data.a_z;
      case (in_data.func)
         v3alu_pkg::FN_SCALE: begin
            y[0] = in_data.scale_factor;
            y[1] = in_data.scale_factor;
            y[2] = in_data.scale_factor;
         end
         v3alu_pkg::FN_CROSS: begin
            x[0] = in_data.a_y;  y[0] = in_data.b_z;
            x[1] = in_data.a_z;  y[1] = in_data.b_y;
            x[2] = in_data.a_z;  y[2] = in_data.b_x;
            x[3] = in_data.a_x;  y[3] = in_data.b_z;
            x[4] = in_data.a_x;  y[4] = in_data.b_y;
            x[5] = in_data.a_y;  y[5] = in_data.b_x;
         end
         default: begin
         end
      endcase
      data_in.func = in_data.func;
      data_in.a    = {in_data.a_z, in_data.a_y, in_data.a_x};
      data_in.b    = {in_data.b_z, in_data.b_y, in_data.b_x};
      for (int i = 0; i < 6; i++) begin
         data_in.prod[i] = 64'(x[i] * y[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/v3alu_comb.sv]
// ----------------------------------------------------------------------------
// v3alu_comb
// sums, scaling, saturation and tolerance tests, registered
// ----------------------------------------------------------------------------
module v3alu_comb (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  v3alu_pkg::mul_type  in_data,
   input  logic [30:0]         tolerance,
   output logic                out_valid,
   output v3alu_pkg::tok_type  out_data
);

   logic signed [65:0] a_e [3];
   logic signed [65:0] b_e [3];
   logic signed [65:0] p_e [6];
   logic signed [65:0] d   [3];
   logic [65:0]        ad  [3];
   logic [65:0]        az  [3];
   logic [63:0]        sum_sq;
   logic [63:0]        sq_q;
   logic [63:0]        ud;
   logic [63:0]        one;
   v3alu_pkg::sat_type sv [3];
   v3alu_pkg::sat_type ss;
   logic               test;
   v3alu_pkg::tok_type tok_in;
   v3alu_pkg::tok_type tok_ff;
   logic               valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_e[i] = 66'($signed(in_data.a[i]));
         b_e[i] = 66'($signed(in_data.b[i]));
         d[i]   = a_e[i] - b_e[i];
         ad[i]  = d[i][65] ? 66'(-d[i]) : 66'(d[i]);
         az[i]  = a_e[i][65] ? 66'(-a_e[i]) : 66'(a_e[i]);
      end
      for (int i = 0; i < 6; i++) begin
         p_e[i] = 66'($signed(in_data.prod[i]));
      end
      sum_sq = in_data.prod[3] + in_data.prod[4] + in_data.prod[5];
      sq_q   = sum_sq >> v3alu_pkg::FRAC_BITS;
      one    = 64'd1 << v3alu_pkg::FRAC_BITS;
      ud     = (sq_q >= one) ? (sq_q - one) : (one - sq_q);
      for (int i = 0; i < 3; i++) begin
         sv[i] = '0;
      end
      ss     = '0;
      test   = 1'b0;
      tok_in = '0;
      case (in_data.func)
         v3alu_pkg::FN_NEG: begin
            for (int i = 0; i < 3; i++) sv[i] = v3alu_pkg::sat32(-a_e[i]);
         end
         v3alu_pkg::FN_ADD: begin
            for (int i = 0; i < 3; i++) sv[i] = v3alu_pkg::sat32(a_e[i] + b_e[i]);
         end
         v3alu_pkg::FN_SUB: begin
            for (int i = 0; i < 3; i++) sv[i] = v3alu_pkg::sat32(d[i]);
         end
         v3alu_pkg::FN_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               sv[i] = v3alu_pkg::sat32(p_e[i] >>> v3alu_pkg::FRAC_BITS);
            end
         end
         v3alu_pkg::FN_DOT: begin
            ss = v3alu_pkg::sat32((p_e[0] + p_e[1] + p_e[2]) >>> v3alu_pkg::FRAC_BITS);
         end
         v3alu_pkg::FN_CROSS: begin
            sv[0] = v3alu_pkg::sat32((p_e[0] - p_e[1]) >>> v3alu_pkg::FRAC_BITS);
            sv[1] = v3alu_pkg::sat32((p_e[2] - p_e[3]) >>> v3alu_pkg::FRAC_BITS);
            sv[2] = v3alu_pkg::sat32((p_e[4] - p_e[5]) >>> v3alu_pkg::FRAC_BITS);
         end
         v3alu_pkg::FN_LENSQ: begin
            ss = v3alu_pkg::sat32($signed({2'b00, sq_q}));
         end
         v3alu_pkg::FN_LEN: begin
            tok_in.is_len = 1'b1;
         end
         v3alu_pkg::FN_NORM: begin
            tok_in.is_norm = 1'b1;
         end
         v3alu_pkg::FN_EQ: begin
            test = (ad[0] <= 66'(tolerance)) && (ad[1] <= 66'(tolerance)) &&
                   (ad[2] <= 66'(tolerance));
         end
         v3alu_pkg::FN_ISZERO: begin
            test = (az[0] <= 66'(tolerance)) && (az[1] <= 66'(tolerance)) &&
                   (az[2] <= 66'(tolerance));
         end
         v3alu_pkg::FN_ISUNIT: begin
            test = ud <= 64'(tolerance);
         end
         default: begin
         end
      endcase
      tok_in.res.res_x      = sv[0].val;
      tok_in.res.res_y      = sv[1].val;
      tok_in.res.res_z      = sv[2].val;
      tok_in.res.res_scalar = ss.val;
      tok_in.res.test_true  = test;
      tok_in.res.overflow   = sv[0].ov | sv[1].ov | sv[2].ov | ss.ov;
      tok_in.sum_sq         = sum_sq;
      for (int i = 0; i < 3; i++) begin
         tok_in.mag[i] = in_data.a[i][31] ? 32'(-in_data.a[i]) : in_data.a[i];
         tok_in.neg[i] = in_data.a[i][31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = tok_ff;

endmodule

[sv/v3alu_sqrt.sv]
// ----------------------------------------------------------------------------
// v3alu_sqrt
// pipelined integer square root of the sum of squares, one root bit a stage
// ----------------------------------------------------------------------------
module v3alu_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  v3alu_pkg::tok_type  in_data,
   output logic                out_valid,
   output v3alu_pkg::tok_type  out_data
);

   localparam int N = v3alu_pkg::SQRT_STEPS;

   logic [63:0]        n_src   [N];
   logic [63:0]        r_src   [N];
   v3alu_pkg::tok_type tok_src [N];
   logic               v_src   [N];
   logic [63:0]        n_in    [N];
   logic [63:0]        r_in    [N];
   logic [63:0]        n_ff    [N];
   logic [63:0]        r_ff    [N];
   v3alu_pkg::tok_type tok_ff  [N];
   logic [N-1:0]       valid_ff;

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      logic        ge;

      if (k == 0) begin : g_first
         assign n_src[k]   = in_data.sum_sq;
         assign r_src[k]   = '0;
         assign tok_src[k] = in_data;
         assign v_src[k]   = in_valid;
      end else begin : g_next
         assign n_src[k]   = n_ff[k-1];
         assign r_src[k]   = r_ff[k-1];
         assign tok_src[k] = tok_ff[k-1];
         assign v_src[k]   = valid_ff[k-1];
      end

      assign trial   = r_src[k] + BIT;
      assign ge      = n_src[k] >= trial;
      assign n_in[k] = ge ? (n_src[k] - trial) : n_src[k];
      assign r_in[k] = ge ? ((r_src[k] >> 1) + BIT) : (r_src[k] >> 1);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_src[k];
         end
      end

      always_ff @(posedge clock) begin
         n_ff[k]   <= n_in[k];
         r_ff[k]   <= r_in[k];
         tok_ff[k] <= tok_src[k];
      end
   end

   always_comb begin
      out_data      = tok_ff[N-1];
      out_data.root = r_ff[N-1][31:0];
   end

   assign out_valid = valid_ff[N-1];

endmodule

[sv/v3alu_div.sv]
// ----------------------------------------------------------------------------
// v3alu_div
// three-lane restoring divider for normalize, then final result assembly
// ----------------------------------------------------------------------------
module v3alu_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  v3alu_pkg::tok_type  in_data,
   output logic                out_valid,
   output v3alu_pkg::rsp_type  out_data
);

   localparam int N = v3alu_pkg::Q_BITS;
   localparam int W = v3alu_pkg::DIV_W;

   logic [W-1:0]       rem_src [N][3];
   logic [N-1:0]       q_src   [N][3];
   v3alu_pkg::tok_type tok_src [N];
   logic               v_src   [N];
   logic [W-1:0]       rem_ff  [N][3];
   logic [N-1:0]       q_ff    [N][3];
   v3alu_pkg::tok_type tok_ff  [N];
   logic [N-1:0]       valid_ff;
   v3alu_pkg::tok_type last;
   logic [31:0]        qv      [3];
   v3alu_pkg::rsp_type rsp_in;
   v3alu_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff;

   for (genvar j = 0; j < N; j++) begin : g_step
      localparam int POS = v3alu_pkg::FRAC_BITS - j;
      logic [W-1:0] dsh;
      logic [W-1:0] rem_in [3];
      logic [N-1:0] q_in   [3];

      if (j == 0) begin : g_first
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_src[j][l] = W'({in_data.mag[l], {v3alu_pkg::FRAC_BITS{1'b0}}});
            assign q_src[j][l]   = '0;
         end
         assign tok_src[j] = in_data;
         assign v_src[j]   = in_valid;
      end else begin : g_next
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_src[j][l] = rem_ff[j-1][l];
            assign q_src[j][l]   = q_ff[j-1][l];
         end
         assign tok_src[j] = tok_ff[j-1];
         assign v_src[j]   = valid_ff[j-1];
      end

      assign dsh = W'(tok_src[j].root) << POS;

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            q_in[l] = q_src[j][l];
            if (rem_src[j][l] >= dsh) begin
               rem_in[l]    = rem_src[j][l] - dsh;
               q_in[l][POS] = 1'b1;
            end else begin
               rem_in[l] = rem_src[j][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= v_src[j];
         end
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[j][l] <= rem_in[l];
            q_ff[j][l]   <= q_in[l];
         end
         tok_ff[j] <= tok_src[j];
      end
   end

   always_comb begin
      last   = tok_ff[N-1];
      rsp_in = last.res;
      for (int l = 0; l < 3; l++) begin
         qv[l] = 32'(q_ff[N-1][l]);
      end
      if (last.is_len) begin
         if (last.root > 32'h7fff_ffff) begin
            rsp_in.res_scalar = 32'h7fff_ffff;
            rsp_in.overflow   = 1'b1;
         end else begin
            rsp_in.res_scalar = last.root;
         end
      end
      if (last.is_norm && (last.root != '0)) begin
         rsp_in.res_x = last.neg[0] ? -qv[0] : qv[0];
         rsp_in.res_y = last.neg[1] ? -qv[1] : qv[1];
         rsp_in.res_z = last.neg[2] ? -qv[2] : qv[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for vec3_alu_unit: drives command beats, some phases
// with random gaps, predicts each result in fixed point and checks every
// result beat in order, with tolerance writes between phases
// ----------------------------------------------------------------------------
module testbench;

   class vec_scoreboard;
      v3alu_pkg::rsp_type pending[$];
      int                 mismatches;
      int                 failures;

      function void note_command(v3alu_pkg::rsp_type r);
         pending.push_back(r);
      endfunction

      function void check_result(v3alu_pkg::rsp_type got);
         v3alu_pkg::rsp_type exp;
         if (pending.size() == 0) begin
            failures++;
            if (mismatches++ < 10) $display("unexpected result beat %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got.res_x !== exp.res_x || got.res_y !== exp.res_y ||
             got.res_z !== exp.res_z || got.res_scalar !== exp.res_scalar ||
             got.test_true !== exp.test_true || got.overflow !== exp.overflow) begin
            failures++;
            if (mismatches++ < 10)
               $display("mismatch exp x=%h y=%h z=%h s=%h t=%b o=%b got x=%h y=%h z=%h s=%h t=%b o=%b",
                  exp.res_x, exp.res_y, exp.res_z, exp.res_scalar, exp.test_true,
                  exp.overflow, got.res_x, got.res_y, got.res_z, got.res_scalar,
                  got.test_true, got.overflow);
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   v3alu_pkg::req_type req_data = '0;
   logic               rsp_valid;
   v3alu_pkg::rsp_type rsp_data;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [30:0]        csr_data = '0;

   vec_scoreboard board = new();
   logic [30:0]   tol_model = v3alu_pkg::TOL_RESET;
   int            send_idle_pct = 0;

   vec3_alu_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_data);
   end

   initial begin
      #400000;
      $display("testbench failed");
      $finish;
   end

   function automatic logic signed [31:0] clamp(input logic signed [127:0] v,
                                                inout logic ov);
      if (v > 128'sd2147483647) begin
         ov = 1;
         return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
         ov = 1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] n);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= r + bitv) begin
            n -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] abs_diff(input logic signed [63:0] x,
                                            input logic signed [63:0] y);
      return x >= y ? x - y : y - x;
   endfunction

   function automatic v3alu_pkg::rsp_type predict_vec_op(input v3alu_pkg::req_type c);
      v3alu_pkg::rsp_type r;
      logic ov;
      logic signed [63:0] a[3], b[3], s;
      logic signed [127:0] w;
      logic [63:0] sumsq, root, q, one, mag;
      r = '0;
      ov = 0;
      a[0] = c.a_x; a[1] = c.a_y; a[2] = c.a_z;
      b[0] = c.b_x; b[1] = c.b_y; b[2] = c.b_z;
      s = c.scale_factor;
      sumsq = 0;
      for (int i = 0; i < 3; i++) sumsq += a[i] * a[i];
      one = 64'd1 << v3alu_pkg::FRAC_BITS;
      case (c.func)
         v3alu_pkg::FN_NEG: begin
            r.res_x = clamp(-a[0], ov); r.res_y = clamp(-a[1], ov); r.res_z = clamp(-a[2], ov);
         end
         v3alu_pkg::FN_ADD: begin
            r.res_x = clamp(a[0] + b[0], ov); r.res_y = clamp(a[1] + b[1], ov);
            r.res_z = clamp(a[2] + b[2], ov);
         end
         v3alu_pkg::FN_SUB: begin
            r.res_x = clamp(a[0] - b[0], ov); r.res_y = clamp(a[1] - b[1], ov);
            r.res_z = clamp(a[2] - b[2], ov);
         end
         v3alu_pkg::FN_SCALE: begin
            r.res_x = clamp((128'(a[0]) * s) >>> v3alu_pkg::FRAC_BITS, ov);
            r.res_y = clamp((128'(a[1]) * s) >>> v3alu_pkg::FRAC_BITS, ov);
            r.res_z = clamp((128'(a[2]) * s) >>> v3alu_pkg::FRAC_BITS, ov);
         end
         v3alu_pkg::FN_DOT: begin
            w = 128'(a[0]) * b[0] + 128'(a[1]) * b[1] + 128'(a[2]) * b[2];
            r.res_scalar = clamp(w >>> v3alu_pkg::FRAC_BITS, ov);
         end
         v3alu_pkg::FN_CROSS: begin
            r.res_x = clamp((128'(a[1]) * b[2] - 128'(a[2]) * b[1]) >>> v3alu_pkg::FRAC_BITS,
                            ov);
            r.res_y = clamp((128'(a[2]) * b[0] - 128'(a[0]) * b[2]) >>> v3alu_pkg::FRAC_BITS,
                            ov);
            r.res_z = clamp((128'(a[0]) * b[1] - 128'(a[1]) * b[0]) >>> v3alu_pkg::FRAC_BITS,
                            ov);
         end
         v3alu_pkg::FN_LENSQ: r.res_scalar = clamp({64'd0, sumsq >> v3alu_pkg::FRAC_BITS}, ov);
         v3alu_pkg::FN_LEN:   r.res_scalar = clamp({64'd0, root64(sumsq)}, ov);
         v3alu_pkg::FN_NORM: begin
            root = root64(sumsq);
            if (root != 0) begin
               w = 0;
               for (int i = 0; i < 3; i++) begin
                  mag = a[i] < 0 ? -a[i] : a[i];
                  q = (mag << v3alu_pkg::FRAC_BITS) / root;
                  w = a[i] < 0 ? -128'(q) : 128'(q);
                  if (i == 0) r.res_x = clamp(w, ov);
                  else if (i == 1) r.res_y = clamp(w, ov);
                  else r.res_z = clamp(w, ov);
               end
            end
         end
         v3alu_pkg::FN_EQ: r.test_true = abs_diff(a[0], b[0]) <= tol_model &&
            abs_diff(a[1], b[1]) <= tol_model && abs_diff(a[2], b[2]) <= tol_model;
         v3alu_pkg::FN_ISZERO: r.test_true = abs_diff(a[0], 0) <= tol_model &&
            abs_diff(a[1], 0) <= tol_model && abs_diff(a[2], 0) <= tol_model;
         v3alu_pkg::FN_ISUNIT: begin
            q = sumsq >> v3alu_pkg::FRAC_BITS;
            r.test_true = (q >= one ? q - one : one - q) <= tol_model;
         end
         default: ;
      endcase
      r.overflow = ov;
      return r;
   endfunction

   task automatic send_command(input v3alu_pkg::req_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_data <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_command(predict_vec_op(c));
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_tolerance(input logic [30:0] v);
      drain();
      repeat (v3alu_pkg::LATENCY + 4) @(negedge clock);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tol_model = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_val();
      case ($urandom_range(7))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 0;
         3: return 32'(signed'($urandom_range(131072))) - 32'sd65536;
         4: return $urandom_range(2000) - 1000;
         5: return 32'h00010000;
         default: return $urandom;
      endcase
   endfunction

   function automatic v3alu_pkg::req_type random_command();
      v3alu_pkg::req_type c;
      c.func = 4'($urandom_range(15));
      c.a_x = pick_val(); c.a_y = pick_val(); c.a_z = pick_val();
      if ($urandom_range(3) == 0) begin
         c.b_x = c.a_x + $urandom_range(200) - 100;
         c.b_y = c.a_y + $urandom_range(200) - 100;
         c.b_z = c.a_z + $urandom_range(200) - 100;
      end else begin
         c.b_x = pick_val(); c.b_y = pick_val(); c.b_z = pick_val();
      end
      c.scale_factor = pick_val();
      return c;
   endfunction

   function automatic v3alu_pkg::req_type make_cmd(input logic [3:0] f, input logic [31:0] v,
                                                   input logic [31:0] w);
      return '{func: f, a_x: v, a_y: v, a_z: v, b_x: w, b_y: w, b_z: w,
               scale_factor: w};
   endfunction

   initial begin
      logic [30:0] tols[4];
      tols = '{31'd0, 31'h7fffffff, 31'd1000, 31'd66};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      while (busy) @(negedge clock);
      for (int f = 0; f < 16; f++) begin
         send_command(make_cmd(4'(f), 32'h80000000, 32'h7fffffff));
      end
      send_command(make_cmd(v3alu_pkg::FN_NORM, 0, 0));
      send_command(make_cmd(v3alu_pkg::FN_ISUNIT, 32'h00010000, 0));
      send_command('{func: v3alu_pkg::FN_ISUNIT, a_x: 32'h00010000, a_y: 0, a_z: 0,
                     b_x: 0, b_y: 0, b_z: 0, scale_factor: 0});
      send_command(make_cmd(v3alu_pkg::FN_EQ, 32'h7fffffff, 32'h7fffffbd));
      send_command(make_cmd(v3alu_pkg::FN_ISZERO, 32'hffffffbe, 0));
      send_command(make_cmd(v3alu_pkg::FN_SCALE, 32'hffffffff, 32'h00000001));
      for (int p = 0; p < 4; p++) begin
         write_tolerance(tols[p]);
         send_idle_pct = p == 0 ? 25 : (p == 1 ? 62 : 0);
         for (int n = 0; n < 160; n++) send_command(random_command());
      end
      drain();
      repeat (v3alu_pkg::LATENCY + 8) @(negedge clock);
      if (board.failures == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule

[filelist.f]
+incdir+sv
sv/v3alu_pkg.sv
sv/v3alu_mul.sv
sv/v3alu_comb.sv
sv/v3alu_sqrt.sv
sv/v3alu_div.sv
sv/vec3_alu_unit.sv
tb/sv/testbench.sv
